/* design/mts_pkg.sv */
// Shared types, codes and constants for the minimum-tracking stack.
package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int WORD_W              = 32;
    localparam int ITEM_COUNT_W        = 7;

    // Opcodes; the unused fourth code behaves as a peek
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Minimum reported when nothing is stored
    localparam logic signed [WORD_W-1:0] EMPTY_MIN = -32'sd1;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic signed [WORD_W-1:0] minimum;
        logic [ITEM_COUNT_W-1:0]  item_count;
        logic [1:0]               status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic push;        // store the word, result at once
        logic pop_start;   // read the entry below the top
        logic pop_finish;  // refresh the top from the read, give the result
        logic respond;     // result from the top registers only
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } dp_status_t;

endpackage

/* design/mts_ctrl.sv */
// Controller: handshakes, operation decode and the pop sequence.
module mts_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    output logic               out_valid,
    input  logic               out_ready,
    input  mts_pkg::dp_status_t dp_status,
    output mts_pkg::dp_cmd_t    dp_cmd
);
    import mts_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   load_out;

    // A new transfer is taken only when the result slot is free or emptying now
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd = '0;
        if (accept)
        begin
            case (opcode)
                OP_PUSH:
                begin
                    if (dp_status.full)
                        dp_cmd.respond = 1'b1;
                    else
                        dp_cmd.push = 1'b1;
                end
                OP_POP:
                begin
                    if (dp_status.empty)
                        dp_cmd.respond = 1'b1;
                    else
                        dp_cmd.pop_start = 1'b1;
                end
                default:
                begin
                    dp_cmd.respond = 1'b1;
                end
            endcase
        end
        if (state_reg == S_POP)
            dp_cmd.pop_finish = 1'b1;
    end

    assign load_out = dp_cmd.push || dp_cmd.respond || dp_cmd.pop_finish;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (dp_cmd.pop_start)
                    state_next = S_POP;
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/mts_dp.sv */
// Datapath: stack memory, cached top entry, fill count and result register.
module mts_dp
#(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mts_pkg::in_item_t   in_data,
    input  mts_pkg::dp_cmd_t    dp_cmd,
    output mts_pkg::dp_status_t dp_status,
    output mts_pkg::out_item_t  out_data
);
    import mts_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // Each entry holds the word (upper half) and the running minimum (lower half)
    logic [2*WORD_W-1:0]       stack_mem_reg [STACK_DEPTH];
    logic [2*WORD_W-1:0]       rd_data_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [WORD_W-1:0]  top_val_reg;
    logic signed [WORD_W-1:0]  top_val_next;
    logic signed [WORD_W-1:0]  top_min_reg;
    logic signed [WORD_W-1:0]  top_min_next;
    out_item_t                 out_reg;
    out_item_t                 out_next;

    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [WORD_W-1:0]  push_min;
    logic signed [WORD_W-1:0]  rd_val;
    logic signed [WORD_W-1:0]  rd_min;

    assign dp_status.empty = (count_reg == '0);
    assign dp_status.full  = (count_reg == CNT_W'(STACK_DEPTH));

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign rd_addr = ADDR_W'(count_reg - CNT_W'(2));
    assign rd_val  = rd_data_reg[2*WORD_W-1:WORD_W];
    assign rd_min  = rd_data_reg[WORD_W-1:0];

    assign push_min = (!dp_status.empty && (top_min_reg < in_data.push_value))
                      ? top_min_reg : in_data.push_value;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.push)
            stack_mem_reg[wr_addr] <= {in_data.push_value, push_min};
        if (dp_cmd.pop_start)
            rd_data_reg <= stack_mem_reg[rd_addr];
    end

    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        out_next     = out_reg;

        if (dp_cmd.push)
        begin
            count_next          = count_reg + CNT_W'(1);
            top_val_next        = in_data.push_value;
            top_min_next        = push_min;
            out_next.top_value  = in_data.push_value;
            out_next.minimum    = push_min;
            out_next.item_count = ITEM_COUNT_W'(count_next);
            out_next.status     = ST_OK;
        end
        else if (dp_cmd.pop_finish)
        begin
            // Entry below the old top becomes the new top
            count_next          = count_reg - CNT_W'(1);
            top_val_next        = rd_val;
            top_min_next        = rd_min;
            out_next.top_value  = top_val_reg;
            out_next.minimum    = (count_next == '0) ? EMPTY_MIN : rd_min;
            out_next.item_count = ITEM_COUNT_W'(count_next);
            out_next.status     = ST_OK;
        end
        else if (dp_cmd.respond)
        begin
            out_next.item_count = ITEM_COUNT_W'(count_reg);
            if (in_data.opcode == OP_PUSH)
            begin
                out_next.top_value = top_val_reg;
                out_next.minimum   = top_min_reg;
                out_next.status    = ST_FULL;
            end
            else if (dp_status.empty)
            begin
                out_next.top_value = '0;
                out_next.minimum   = EMPTY_MIN;
                out_next.status    = ST_EMPTY;
            end
            else
            begin
                out_next.top_value = top_val_reg;
                out_next.minimum   = top_min_reg;
                out_next.status    = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not raise the fill count");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.pop_finish |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not lower the fill count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.pop_start |-> !dp_status.empty && !dp_cmd.push)
        else $error("pop started on an empty stack or alongside a push");
`endif

endmodule

/* design/min_tracking_stack.sv */
// Top level of the minimum-tracking stack: controller and datapath.
//
//  channel   signals                        payload
//  input     in_valid / in_ready            in_data  (opcode, push_value)
//  output    out_valid / out_ready          out_data (top_value, minimum,
//                                                     item_count, status)
//
// Push, peek and the empty/full cases load the result directly; a pop passes
// through the pop state, waiting on the registered memory read of the entry below the top.
// Reset clears the fill count, the controller state and the result valid;
// memory contents need no clearing pass.
// A new transfer is refused while a result waits and out_ready is low, and
// while the controller is in its pop state.
module min_tracking_stack
#(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mts_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mts_pkg::out_item_t out_data
);
    import mts_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    mts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (in_data.opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mts_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .out_data  (out_data)
    );

endmodule

/* test/tb.sv */
// Testbench for the minimum-tracking stack: random valid/ready traffic against a predictor.
`timescale 1ns / 1ps

module tb;
    import mts_pkg::*;

    localparam int DEPTH          = DEFAULT_STACK_DEPTH;
    localparam int IDLE_PERCENT   = 29;
    localparam int QUIET_FIRST    = 600;
    localparam int QUIET_LAST     = 1400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1230;

    // the unused fourth opcode, which behaves as a peek
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t  pending_ops[$];
    out_item_t expected_results[$];

    // predictor state
    logic signed [WORD_W-1:0] word_stack[DEPTH];
    logic signed [WORD_W-1:0] min_stack[DEPTH];
    int                       depth_used = 0;

    int errors   = 0;
    int cycle_no = 0;
    int stuck    = 0;

    min_tracking_stack #(.STACK_DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic out_item_t stack_result(in_item_t op_item);
        out_item_t                r;
        logic signed [WORD_W-1:0] run_min;
        r = '0;
        if (op_item.opcode == OP_PUSH)
        begin
            if (depth_used >= DEPTH)
            begin
                r.top_value = word_stack[DEPTH-1];
                r.minimum   = min_stack[depth_used-1];
                r.status    = ST_FULL;
            end
            else
            begin
                run_min = op_item.push_value;
                if (depth_used != 0 && min_stack[depth_used-1] < run_min)
                    run_min = min_stack[depth_used-1];
                word_stack[depth_used] = op_item.push_value;
                min_stack[depth_used]  = run_min;
                depth_used++;
                r.top_value = op_item.push_value;
                r.minimum   = run_min;
                r.status    = ST_OK;
            end
        end
        else if (depth_used == 0)
        begin
            r.top_value = '0;
            r.minimum   = EMPTY_MIN;
            r.status    = ST_EMPTY;
        end
        else if (op_item.opcode == OP_POP)
        begin
            r.top_value = word_stack[depth_used-1];
            depth_used--;
            r.minimum   = (depth_used == 0) ? EMPTY_MIN : min_stack[depth_used-1];
            r.status    = ST_OK;
        end
        else
        begin
            r.top_value = word_stack[depth_used-1];
            r.minimum   = min_stack[depth_used-1];
            r.status    = ST_OK;
        end
        r.item_count = ITEM_COUNT_W'(depth_used);
        return r;
    endfunction

    function automatic logic quiet_now();
        return cycle_no >= QUIET_FIRST && cycle_no < QUIET_LAST;
    endfunction

    // driver: prediction is made at the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(stack_result(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 &&
                    (quiet_now() || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_ops.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: top_value %0d minimum %0d count %0d status %0d",
                           out_data.top_value, out_data.minimum, out_data.item_count,
                           out_data.status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, out_data.top_value);
                        errors++;
                    end
                    if (out_data.minimum !== want.minimum)
                    begin
                        $error("minimum: expected %0d, got %0d", want.minimum, out_data.minimum);
                        errors++;
                    end
                    if (out_data.item_count !== want.item_count)
                    begin
                        $error("item_count: expected %0d, got %0d",
                               want.item_count, out_data.item_count);
                        errors++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        errors++;
                    end
                end
            end
            out_ready <= quiet_now() || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_no <= 0;
            stuck    <= 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_op(input logic [1:0] code, input logic signed [WORD_W-1:0] word);
        in_item_t op_item;
        op_item.opcode     = code;
        op_item.push_value = word;
        pending_ops.push_back(op_item);
    endtask

    // extremes, near-ties around zero and full random words
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $signed($urandom_range(0, 16)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [1:0] pick_non_push();
        case ($urandom_range(0, 2))
            0: return OP_POP;
            1: return OP_PEEK;
            default: return OP_SPARE;
        endcase
    endfunction

    initial
    begin
        int issued;
        int run_len;

        // directed: empty cases, extremes, equal minima, emptying pop
        add_op(OP_PEEK, 32'sd7);
        add_op(OP_POP, -32'sd7);
        add_op(OP_SPARE, 32'sd0);
        add_op(OP_PUSH, 32'sd0);
        add_op(OP_PUSH, 32'sh7FFF_FFFF);
        add_op(OP_PUSH, 32'sh8000_0000);
        add_op(OP_PUSH, -32'sd1);
        add_op(OP_PEEK, 32'sd0);
        add_op(OP_SPARE, 32'sh5555_5555);
        add_op(OP_PUSH, 32'sh8000_0000);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_PUSH, 32'sd5);
        add_op(OP_PUSH, 32'sd5);
        add_op(OP_PUSH, 32'sd3);
        add_op(OP_PEEK, -32'sd1);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);
        add_op(OP_POP, 32'sd0);

        // first runs reach the full and empty ends for certain
        for (int i = 0; i < DEPTH + 4; i++)
            add_op(OP_PUSH, pick_word());
        for (int i = 0; i < DEPTH + 4; i++)
            add_op(OP_POP, $signed($urandom()));
        issued = 2 * (DEPTH + 4);

        while (issued < RANDOM_ITEMS)
        begin
            run_len = $urandom_range(1, DEPTH + 8);
            case ($urandom_range(0, 3))
                0: for (int i = 0; i < run_len; i++)
                       add_op(OP_PUSH, pick_word());
                1: for (int i = 0; i < run_len; i++)
                       add_op(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP,
                              $signed($urandom()));
                default:
                    for (int i = 0; i < run_len; i++)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            add_op(OP_PUSH, pick_word());
                        else
                            add_op(pick_non_push(), $signed($urandom()));
                    end
            endcase
            issued += run_len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* min_tracking_stack.f */
design/mts_pkg.sv
design/mts_ctrl.sv
design/mts_dp.sv
design/min_tracking_stack.sv
test/tb.sv
